>>> sv/sgps_pkg.sv
// Shared types and constants of the sample-to-gray pixel scaler.
// Used by the channel interfaces, the divider, the square-root unit and the top level.
// Depends on nothing.
package sgps_pkg;

    // Default sample and register width
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Gray level width and its fixed levels
    localparam int GRAY_WIDTH = 8;
    localparam logic [GRAY_WIDTH-1:0] GRAY_BLANK = 8'd0;
    localparam logic [GRAY_WIDTH-1:0] GRAY_MIN   = 8'd1;
    localparam logic [GRAY_WIDTH-1:0] GRAY_MAX   = 8'd254;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LOW       = 2'd0,
        REG_HIGH      = 2'd1,
        REG_BLANK     = 2'd2,
        REG_SQRT_MODE = 2'd3
    } reg_index_t;

    // Register reset values, truncated to the sample width at use
    localparam logic signed [63:0] LOW_RESET   = 64'sd0;
    localparam logic signed [63:0] HIGH_RESET  = 64'sd65535;
    localparam logic signed [63:0] BLANK_RESET = -64'sd2147483648;

    // Quotient bits of the scaled division, and the two scale factors
    localparam int QBITS = 18;
    localparam logic [QBITS-1:0] LIN_SCALE  = 18'd508;
    localparam logic [QBITS-1:0] SQRT_SCALE = 18'd258064;

    // Square-root steps: one result bit each, over a QBITS-bit radicand
    localparam int SQRT_STEPS = QBITS / 2;
    localparam int ROOT_WIDTH = QBITS + 1;

    // Side information that travels with each request down the pipeline
    typedef struct packed {
        logic                  mode;
        logic                  fixed_en;
        logic [GRAY_WIDTH-1:0] fixed_gray;
    } side_t;

endpackage

>>> sv/sgps_if.sv
// Valid/ready channel interfaces of the sample-to-gray pixel scaler:
// sample input, gray output and configuration write.
// Depends on sgps_pkg.
interface sgps_sample_if #(
    parameter int SAMPLE_WIDTH = sgps_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface sgps_gray_if;
    logic                            valid;
    logic                            ready;
    logic [sgps_pkg::GRAY_WIDTH-1:0] gray;

    modport source (output valid, output gray, input ready);
    modport sink (input valid, input gray, output ready);
endinterface

interface sgps_cfg_if #(
    parameter int SAMPLE_WIDTH = sgps_pkg::SAMPLE_WIDTH_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic [sgps_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [SAMPLE_WIDTH-1:0]              data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/sample_to_gray_pixel_scaler.sv
// Sample-to-gray pixel scaler: maps one signed sample to an 8-bit gray level.
// Throughput: one sample per cycle unless the output stalls a full pipeline. The level is registered
// through 31 stages, the first loaded at the accepting edge: compare and clamp 2, multiply 1,
// divider 18 at one quotient bit each, square root 9, output 1.
// Empty stages close up while the output is stalled; reset clears all valid bits and
// loads low 0, high 65535, blank -2^31, linear mode. Depends on sgps_pkg, sgps_if, div, sqrt.
module sample_to_gray_pixel_scaler #(
    parameter int SAMPLE_WIDTH = sgps_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    sgps_sample_if.sink    samples,
    sgps_gray_if.source    grays,
    sgps_cfg_if.sink       cfg
);

    localparam int QB         = sgps_pkg::QBITS;
    localparam int RW         = sgps_pkg::ROOT_WIDTH;
    localparam int GW         = sgps_pkg::GRAY_WIDTH;
    localparam int PROD_WIDTH = SAMPLE_WIDTH + QB;
    localparam int DIV_FIRST  = 3;
    localparam int SQRT_FIRST = DIV_FIRST + QB;
    localparam int OUT_STAGE  = SQRT_FIRST + sgps_pkg::SQRT_STEPS;
    localparam int NSTAGE     = OUT_STAGE + 1;

    // Clip a level to the non-blank range
    function automatic logic [GW-1:0] clip_level(input logic [RW-1:0] v);
        if (v < RW'(sgps_pkg::GRAY_MIN))
            return sgps_pkg::GRAY_MIN;
        else if (v > RW'(sgps_pkg::GRAY_MAX))
            return sgps_pkg::GRAY_MAX;
        else
            return v[GW-1:0];
    endfunction

    // Configuration registers
    logic signed [SAMPLE_WIDTH-1:0] low_reg;
    logic signed [SAMPLE_WIDTH-1:0] high_reg;
    logic signed [SAMPLE_WIDTH-1:0] blank_reg;
    logic                           mode_reg;

    // Values derived from the window, refreshed every cycle
    logic [SAMPLE_WIDTH-1:0] span_reg;
    logic                    empty_reg;
    logic                    inverted_reg;

    // Pipeline control
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_next;
    logic [NSTAGE-1:0] en;
    logic              advance;

    // Stage A: captured sample and its compares
    logic signed [SAMPLE_WIDTH-1:0] a_sample_reg;
    logic                           a_blank_reg;
    logic                           a_below_reg;
    logic                           a_above_reg;

    // Stage B: offset into the window
    logic [SAMPLE_WIDTH-1:0] b_d_reg;
    sgps_pkg::side_t         b_side_reg;
    sgps_pkg::side_t         b_side_next;

    // Stage C: scaled numerator
    logic [QB-1:0]         scale;
    logic [PROD_WIDTH-1:0] c_prod_reg;
    logic [PROD_WIDTH-1:0] c_prod_next;
    sgps_pkg::side_t       c_side_reg;

    // Divider and square-root links
    logic [QB-1:0]     div_q;
    sgps_pkg::side_t   div_side;
    logic [QB:0]       lin_sum;
    sgps_pkg::side_t   sq_side_in;
    logic [RW-1:0]     sq_root;
    sgps_pkg::side_t   sq_side;
    logic [RW:0]       root_sum;

    // Output register
    logic [GW-1:0] gray_reg;
    logic [GW-1:0] gray_next;

    // Take register writes; every index names a register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= SAMPLE_WIDTH'(sgps_pkg::LOW_RESET);
            high_reg  <= SAMPLE_WIDTH'(sgps_pkg::HIGH_RESET);
            blank_reg <= SAMPLE_WIDTH'(sgps_pkg::BLANK_RESET);
            mode_reg  <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (sgps_pkg::reg_index_t'(cfg.index))
                sgps_pkg::REG_LOW:       low_reg   <= cfg.data;
                sgps_pkg::REG_HIGH:      high_reg  <= cfg.data;
                sgps_pkg::REG_BLANK:     blank_reg <= cfg.data;
                sgps_pkg::REG_SQRT_MODE: mode_reg  <= cfg.data[0];
                default:                 mode_reg  <= mode_reg;
            endcase
        end
    end

    // Precompute window span and its special shapes
    always_ff @(posedge clk)
    begin
        span_reg     <= SAMPLE_WIDTH'(high_reg - low_reg);
        empty_reg    <= high_reg == low_reg;
        inverted_reg <= high_reg < low_reg;
    end

    // A stage may load when any stage at or after it is empty, or the output drains
    assign advance = !v_reg[NSTAGE-1] || grays.ready;

    for (genvar i = 0; i < NSTAGE; i++) begin : g_en
        assign en[i] = advance || !(&v_reg[NSTAGE-1:i]);
    end

    assign samples.ready = en[0];
    assign v_next = (en & {v_reg[NSTAGE-2:0], samples.valid}) | (~en & v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // Stage A: compare the raw sample against blank and window edges
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_sample_reg <= samples.sample;
            a_blank_reg  <= samples.sample == blank_reg;
            a_below_reg  <= samples.sample < low_reg;
            a_above_reg  <= samples.sample > high_reg;
        end
    end

    // Stage B: clamp and offset; mark blank, empty and inverted windows as fixed levels
    always_comb
    begin
        b_side_next.mode       = mode_reg;
        b_side_next.fixed_en   = a_blank_reg || empty_reg || inverted_reg;
        if (a_blank_reg)
            b_side_next.fixed_gray = sgps_pkg::GRAY_BLANK;
        else if (empty_reg)
            b_side_next.fixed_gray = sgps_pkg::GRAY_MIN;
        else
            b_side_next.fixed_gray = sgps_pkg::GRAY_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            if (a_above_reg)
                b_d_reg <= span_reg;
            else if (a_below_reg)
                b_d_reg <= '0;
            else
                b_d_reg <= SAMPLE_WIDTH'(a_sample_reg - low_reg);
            b_side_reg <= b_side_next;
        end
    end

    // Stage C: scale the offset for the selected curve
    assign scale       = b_side_reg.mode ? sgps_pkg::SQRT_SCALE : sgps_pkg::LIN_SCALE;
    assign c_prod_next = PROD_WIDTH'(b_d_reg) * PROD_WIDTH'(scale);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c_prod_reg <= c_prod_next;
            c_side_reg <= b_side_reg;
        end
    end

    // Divide by the window span
    sgps_div #(
        .DATA_WIDTH (SAMPLE_WIDTH)
    ) u_div (
        .clk           (clk),
        .en            (en[DIV_FIRST +: QB]),
        .divisor       (span_reg),
        .dividend      (c_prod_reg),
        .side          (c_side_reg),
        .quotient      (div_q),
        .quotient_side (div_side)
    );

    // Finish a linear level here; it rides through the root stages as fixed
    assign lin_sum = {1'b0, div_q} + (QB + 1)'(1);

    always_comb
    begin
        sq_side_in = div_side;
        if (!div_side.fixed_en && !div_side.mode)
        begin
            sq_side_in.fixed_en   = 1'b1;
            sq_side_in.fixed_gray = clip_level({1'b0, lin_sum[QB:1]});
        end
    end

    sgps_sqrt u_sqrt (
        .clk       (clk),
        .en        (en[SQRT_FIRST +: sgps_pkg::SQRT_STEPS]),
        .radicand  (div_q),
        .side      (sq_side_in),
        .root      (sq_root),
        .root_side (sq_side)
    );

    // Output stage: round the root, or pass a fixed level
    assign root_sum  = {1'b0, sq_root} + (RW + 1)'(1);
    assign gray_next = sq_side.fixed_en ? sq_side.fixed_gray : clip_level(root_sum[RW:1]);

    always_ff @(posedge clk)
    begin
        if (en[OUT_STAGE])
            gray_reg <= gray_next;
    end

    assign grays.valid = v_reg[NSTAGE-1];
    assign grays.gray  = gray_reg;

endmodule

>>> sv/sgps_div.sv
// Pipelined restoring divider: one quotient bit per stage, QBITS stages.
// Computes floor(dividend / divisor) where the quotient fits in QBITS bits.
// Depends on sgps_pkg.
module sgps_div #(
    parameter int DATA_WIDTH = sgps_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic [sgps_pkg::QBITS-1:0]            en,
    input  logic [DATA_WIDTH-1:0]                 divisor,
    input  logic [DATA_WIDTH+sgps_pkg::QBITS-1:0] dividend,
    input  sgps_pkg::side_t                       side,
    output logic [sgps_pkg::QBITS-1:0]            quotient,
    output sgps_pkg::side_t                       quotient_side
);

    localparam int QB = sgps_pkg::QBITS;

    logic [DATA_WIDTH-1:0] rem_reg  [QB];
    logic [QB-1:0]         tail_reg [QB];
    logic [QB-1:0]         quo_reg  [QB];
    sgps_pkg::side_t       side_reg [QB];

    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [DATA_WIDTH-1:0] rem_prev;
        logic [QB-1:0]         tail_prev;
        logic [QB-1:0]         quo_prev;
        sgps_pkg::side_t       side_prev;
        logic [DATA_WIDTH:0]   trial;
        logic                  take;
        logic [DATA_WIDTH-1:0] rem_next;
        logic [QB-1:0]         tail_next;
        logic [QB-1:0]         quo_next;

        // Load the upper dividend bits as the first partial remainder
        if (j == 0) begin : g_head
            assign rem_prev  = dividend[DATA_WIDTH+QB-1:QB];
            assign tail_prev = dividend[QB-1:0];
            assign quo_prev  = '0;
            assign side_prev = side;
        end else begin : g_link
            assign rem_prev  = rem_reg[j-1];
            assign tail_prev = tail_reg[j-1];
            assign quo_prev  = quo_reg[j-1];
            assign side_prev = side_reg[j-1];
        end

        // Bring down one bit, subtract the divisor where it fits
        assign trial     = {rem_prev, tail_prev[QB-1]};
        assign take      = trial >= {1'b0, divisor};
        assign rem_next  = take ? DATA_WIDTH'(trial - {1'b0, divisor})
                                : trial[DATA_WIDTH-1:0];
        assign tail_next = {tail_prev[QB-2:0], 1'b0};
        assign quo_next  = {quo_prev[QB-2:0], take};

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= rem_next;
                tail_reg[j] <= tail_next;
                quo_reg[j]  <= quo_next;
                side_reg[j] <= side_prev;
            end
        end
    end

    assign quotient      = quo_reg[QB-1];
    assign quotient_side = side_reg[QB-1];

endmodule

>>> sv/sgps_sqrt.sv
// Pipelined integer square root: one root bit per stage, SQRT_STEPS stages.
// Returns floor(sqrt(radicand)) for a QBITS-bit radicand.
// Depends on sgps_pkg.
module sgps_sqrt (
    input  logic                                clk,
    input  logic [sgps_pkg::SQRT_STEPS-1:0]     en,
    input  logic [sgps_pkg::QBITS-1:0]          radicand,
    input  sgps_pkg::side_t                     side,
    output logic [sgps_pkg::ROOT_WIDTH-1:0]     root,
    output sgps_pkg::side_t                     root_side
);

    localparam int STEPS = sgps_pkg::SQRT_STEPS;
    localparam int XW    = sgps_pkg::QBITS;
    localparam int RW    = sgps_pkg::ROOT_WIDTH;

    logic [XW-1:0]   x_reg    [STEPS];
    logic [RW-1:0]   root_reg [STEPS];
    sgps_pkg::side_t side_reg [STEPS];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (STEPS - 1 - j));

        logic [XW-1:0]   x_prev;
        logic [RW-1:0]   root_prev;
        sgps_pkg::side_t side_prev;
        logic [RW-1:0]   trial;
        logic            take;
        logic [XW-1:0]   x_next;
        logic [RW-1:0]   root_next;

        if (j == 0) begin : g_head
            assign x_prev    = radicand;
            assign root_prev = '0;
            assign side_prev = side;
        end else begin : g_link
            assign x_prev    = x_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign side_prev = side_reg[j-1];
        end

        // Try the next root bit, keep it where the remainder allows
        assign trial     = root_prev + BIT;
        assign take      = {1'b0, x_prev} >= trial;
        assign x_next    = take ? XW'({1'b0, x_prev} - trial) : x_prev;
        assign root_next = take ? (root_prev >> 1) + BIT : root_prev >> 1;

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                x_reg[j]    <= x_next;
                root_reg[j] <= root_next;
                side_reg[j] <= side_prev;
            end
        end
    end

    assign root      = root_reg[STEPS-1];
    assign root_side = side_reg[STEPS-1];

endmodule
